/* rtl/rgb_brightness_gain_blend_defines.svh */
// Assertion macros for the RGB gain/blend block.
// Used by rgb_brightness_gain_blend.sv; no other dependencies.
`ifndef RGB_BRIGHTNESS_GAIN_BLEND_DEFINES_SVH
`define RGB_BRIGHTNESS_GAIN_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RGBG_ASSERT_IMP(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("rgbg: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define RGBG_ASSERT_NXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("rgbg: next-cycle check failed");

`endif

/* rtl/rgbg_pkg.sv */
// Package for the RGB gain/blend block: beat types, register codes and
// per-channel gain, scale, blend and distance functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbg_pkg;

    localparam int CHAN_W     = 8;
    localparam int SLIDER_W   = 14;
    localparam int GAIN_W     = 22;   // unity + 256 * max slider fits here
    localparam int GAIN_FRAC  = 16;
    localparam int PROD_W     = CHAN_W + GAIN_W;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int GAIN_ONE   = 65536;
    localparam int NEG_SHIFT  = 4;    // 16 * slider
    localparam int POS_SHIFT  = 8;    // 256 * slider

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    // Blend mode bits: add wins over average.
    localparam int BLEND_ADD_BIT = 0;
    localparam int BLEND_AVG_BIT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE           = 3'd0,
        CFG_RED_SLIDER       = 3'd1,
        CFG_GREEN_SLIDER     = 3'd2,
        CFG_BLUE_SLIDER      = 3'd3,
        CFG_BLEND_MODE       = 3'd4,
        CFG_EXCLUDE_ENABLE   = 3'd5,
        CFG_EXCLUDE_DISTANCE = 3'd6,
        CFG_REFERENCE_COLOR  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
        logic              was_excluded;
    } pixel_out_t;

    // Slider to unsigned gain, 16 fraction bits; negative side floors at 0.
    function automatic logic [GAIN_W-1:0] gain_of(input logic signed [SLIDER_W-1:0] s);
        logic signed [GAIN_W:0] ext;
        logic signed [GAIN_W:0] wide;
        ext = $signed({{(GAIN_W+1-SLIDER_W){s[SLIDER_W-1]}}, s});
        if (s[SLIDER_W-1])
            wide = $signed((GAIN_W+1)'(GAIN_ONE)) + (ext <<< NEG_SHIFT);
        else
            wide = $signed((GAIN_W+1)'(GAIN_ONE)) + (ext <<< POS_SHIFT);
        if (wide[GAIN_W])
            return '0;
        return wide[GAIN_W-1:0];
    endfunction

    // (v * gain) >> 16, clamped to the channel maximum.
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] v,
                                                     input logic [GAIN_W-1:0] gain);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(v) * PROD_W'(gain);
        if (|prod[PROD_W-1:GAIN_FRAC+CHAN_W])
            return CHAN_MAX;
        return prod[GAIN_FRAC+CHAN_W-1:GAIN_FRAC];
    endfunction

    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] orig,
                                                     input logic [CHAN_W-1:0] scaled,
                                                     input logic [1:0]        mode);
        logic [CHAN_W:0] sum;
        sum = {1'b0, orig} + {1'b0, scaled};
        priority if (mode[BLEND_ADD_BIT])
            return sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
        else if (mode[BLEND_AVG_BIT])
            return sum[CHAN_W:1];
        else
            return scaled;
    endfunction

    // Inclusive per-channel distance test.
    function automatic logic near_chan(input logic [CHAN_W-1:0] a,
                                       input logic [CHAN_W-1:0] b,
                                       input logic [CHAN_W-1:0] limit);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= limit;
    endfunction

endpackage

`default_nettype wire

/* rtl/rgb_brightness_gain_blend.sv */
// Top level of the RGB gain/blend block: config registers, two-stage
// pixel pipeline. Depends on rgbg_pkg and rgb_brightness_gain_blend_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_brightness_gain_blend_defines.svh"

// Per-channel RGB gain with blend. Each pixel beat passes an input register
// and a result register in that order, so a result is on res once it has
// passed both and leaves at an edge where res_stall is low; one pixel is taken every
// cycle while the result side keeps up.
// The path between the two registers is one 8x22 multiply per color channel
// followed by clamp and blend, beside the reference-color compare; that multiply
// sets the cycle. A waiting result does not block the input register: a
// new beat is still taken while the result side stalls, until both stages
// are full. Slider writes are turned into gains at write time and held in
// gain registers. Registers may be written only while no beat is in flight;
// the block does not check this. Alpha passes through untouched.
module rgb_brightness_gain_blend (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // pixel side
    input  wire logic                         pix_valid,
    output logic                              pix_stall,
    input  wire rgbg_pkg::pixel_in_t          pix,
    // result side
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output rgbg_pkg::pixel_out_t              res,
    // register writes
    input  wire logic                         cfg_wr_en,
    input  wire logic [rgbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rgbg_pkg::*;

    // ---------------- configuration ----------------
    logic                  enable_reg;
    logic [GAIN_W-1:0]     red_gain_reg;
    logic [GAIN_W-1:0]     green_gain_reg;
    logic [GAIN_W-1:0]     blue_gain_reg;
    logic [1:0]            blend_mode_reg;
    logic                  exclude_enable_reg;
    logic [CHAN_W-1:0]     exclude_distance_reg;
    logic [3*CHAN_W-1:0]   reference_color_reg;

    logic [GAIN_W-1:0]     cfg_gain;

    // Gain from the slider bits of the write data; only used on slider writes.
    assign cfg_gain = gain_of($signed(cfg_data[SLIDER_W-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg           <= 1'b0;
            red_gain_reg         <= GAIN_W'(GAIN_ONE);
            green_gain_reg       <= GAIN_W'(GAIN_ONE);
            blue_gain_reg        <= GAIN_W'(GAIN_ONE);
            blend_mode_reg       <= '0;
            exclude_enable_reg   <= 1'b0;
            exclude_distance_reg <= '0;
            reference_color_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:           enable_reg           <= cfg_data[0];
                CFG_RED_SLIDER:       red_gain_reg         <= cfg_gain;
                CFG_GREEN_SLIDER:     green_gain_reg       <= cfg_gain;
                CFG_BLUE_SLIDER:      blue_gain_reg        <= cfg_gain;
                CFG_BLEND_MODE:       blend_mode_reg       <= cfg_data[1:0];
                CFG_EXCLUDE_ENABLE:   exclude_enable_reg   <= cfg_data[0];
                CFG_EXCLUDE_DISTANCE: exclude_distance_reg <= cfg_data[CHAN_W-1:0];
                CFG_REFERENCE_COLOR:  reference_color_reg  <= cfg_data[3*CHAN_W-1:0];
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic       s1_valid_reg, s1_valid_next;
    logic       res_valid_reg, res_valid_next;
    logic       s1_load;
    logic       s2_load;
    pixel_in_t  s1_pix_reg;
    pixel_out_t res_reg, res_next;

    // Result register frees up when empty or its beat leaves this cycle.
    assign s2_load   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign pix_stall = s1_valid_reg && !s2_load;
    assign s1_load   = pix_valid && !pix_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (s2_load)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ---------------- datapath ----------------
    logic hit;

    // Exclusion: every channel within distance of the reference channel.
    assign hit = exclude_enable_reg
              && near_chan(s1_pix_reg.red_in,   reference_color_reg[23:16],
                           exclude_distance_reg)
              && near_chan(s1_pix_reg.green_in, reference_color_reg[15:8],
                           exclude_distance_reg)
              && near_chan(s1_pix_reg.blue_in,  reference_color_reg[7:0],
                           exclude_distance_reg);

    always_comb
    begin
        res_next.red_out      = s1_pix_reg.red_in;
        res_next.green_out    = s1_pix_reg.green_in;
        res_next.blue_out     = s1_pix_reg.blue_in;
        res_next.alpha_out    = s1_pix_reg.alpha_in;
        res_next.was_excluded = 1'b0;
        if (enable_reg)
        begin
            if (hit)
                res_next.was_excluded = 1'b1;
            else
            begin
                res_next.red_out   = blend_chan(s1_pix_reg.red_in,
                    scale_chan(s1_pix_reg.red_in, red_gain_reg), blend_mode_reg);
                res_next.green_out = blend_chan(s1_pix_reg.green_in,
                    scale_chan(s1_pix_reg.green_in, green_gain_reg), blend_mode_reg);
                res_next.blue_out  = blend_chan(s1_pix_reg.blue_in,
                    scale_chan(s1_pix_reg.blue_in, blue_gain_reg), blend_mode_reg);
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_pix_reg <= pix;
        if (s2_load)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ---------------- checks ----------------
    // A held input beat is never dropped.
    `RGBG_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s2_load, s1_valid_reg)
    // A result beat never overwrites one that is stalled.
    `RGBG_ASSERT_IMP(a_no_overwrite, clk, rst_n, res_valid_reg && res_stall, !s2_load)
    // Alpha travels untouched from input register to result.
    `RGBG_ASSERT_NXT(a_alpha_pass, clk, rst_n, s2_load,
                     res_reg.alpha_out == $past(s1_pix_reg.alpha_in))
    // Disabled block passes color unchanged (red is checked) and never flags exclusion.
    `RGBG_ASSERT_NXT(a_bypass, clk, rst_n, s2_load && !enable_reg,
                     !res_reg.was_excluded && res_reg.red_out == $past(s1_pix_reg.red_in))

endmodule

`default_nettype wire
